// File: hdl/shs_pkg.sv
package shs_pkg;

    localparam int DEF_COUNT_WIDTH = 16;
    localparam int DEF_TIMER_WIDTH = 16;

    localparam int COUNT_IN_W    = 16;
    localparam int INTERVAL_W    = 16;
    localparam int COIL_W        = 4;
    localparam int PHASE_W       = 3;
    localparam int S_TDATA_W     = 24;
    localparam int M_TDATA_W     = 8;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_MOVE = 1'b1;

    localparam logic DIR_BACKWARD = 1'b0;
    localparam logic DIR_FORWARD  = 1'b1;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd1;

    // Half-step rows, bit 0 is the first coil column.
    localparam logic [COIL_W-1:0] HALF_STEP_ROWS [8] = '{
        4'h9, 4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8
    };

    typedef struct packed {
        logic                  opcode;
        logic [COUNT_IN_W-1:0] step_count;
        logic                  direction;
    } t_item;

    typedef struct packed {
        logic [COIL_W-1:0] coils;
        logic              stepped;
        logic              busy_res;
        logic              rejected;
    } t_result;

endpackage

// File: hdl/shs_in_reg.sv
module shs_in_reg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_opcode,
    input  logic [shs_pkg::S_TDATA_W-1:0]     i_data,
    input  logic                              i_take,
    output logic                              o_valid,
    output shs_pkg::t_item                    o_item
);
    import shs_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  n_valid;

    assign o_ready = !r_valid || i_take;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item.opcode     <= i_opcode;
            r_item.step_count <= i_data[COUNT_IN_W-1:0];
            r_item.direction  <= i_data[COUNT_IN_W];
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: hdl/shs_core.sv
module shs_core #(
    parameter int COUNT_WIDTH = shs_pkg::DEF_COUNT_WIDTH,
    parameter int TIMER_WIDTH = shs_pkg::DEF_TIMER_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [shs_pkg::INTERVAL_W-1:0]    i_cfg_wr_data,
    input  logic                              i_fire,
    input  shs_pkg::t_item                    i_item,
    output shs_pkg::t_result                  o_result
);
    import shs_pkg::*;

    logic [INTERVAL_W-1:0]  r_interval;
    logic [PHASE_W-1:0]     r_phase,      n_phase;
    logic [COUNT_WIDTH-1:0] r_steps_left, n_steps_left;
    logic [TIMER_WIDTH-1:0] r_wait,       n_wait;
    logic [COIL_W-1:0]      r_coils,      n_coils;
    logic                   r_moving,     n_moving;
    logic                   r_dir,        n_dir;

    logic [COUNT_WIDTH-1:0] count_in;
    logic [TIMER_WIDTH-1:0] wait_dec;
    logic                   do_step;
    logic                   step_dir;
    logic                   stepped;
    logic                   rejected;

    assign count_in = COUNT_WIDTH'(i_item.step_count);
    assign wait_dec = (r_wait != '0) ? r_wait - 1'b1 : r_wait;

    always_comb begin
        n_phase      = r_phase;
        n_steps_left = r_steps_left;
        n_wait       = r_wait;
        n_coils      = r_coils;
        n_moving     = r_moving;
        n_dir        = r_dir;
        do_step      = 1'b0;
        rejected     = 1'b0;
        step_dir     = r_dir;

        if (i_item.opcode == OP_MOVE) begin
            if (r_moving) begin
                rejected = 1'b1;
            end else if (count_in != '0) begin
                do_step      = 1'b1;
                step_dir     = i_item.direction;
                n_dir        = i_item.direction;
                n_steps_left = count_in - 1'b1;
                n_moving     = 1'b1;
            end
        end else if (r_moving) begin
            n_wait = wait_dec;
            if (wait_dec == '0) begin
                if (r_steps_left != '0) begin
                    do_step      = 1'b1;
                    n_steps_left = r_steps_left - 1'b1;
                end else begin
                    n_moving = 1'b0;
                end
            end
        end

        // A step drives the current row, then moves the phase and restarts the delay.
        if (do_step) begin
            n_coils = HALF_STEP_ROWS[r_phase];
            n_phase = (step_dir == DIR_FORWARD) ? r_phase + 1'b1 : r_phase - 1'b1;
            n_wait  = TIMER_WIDTH'(r_interval);
        end
        stepped = do_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval   <= INTERVAL_RESET;
            r_phase      <= '0;
            r_steps_left <= '0;
            r_wait       <= '0;
            r_coils      <= '0;
            r_moving     <= 1'b0;
            r_dir        <= DIR_BACKWARD;
        end else begin
            if (i_cfg_wr_en) begin
                r_interval <= i_cfg_wr_data;
            end
            if (i_fire) begin
                r_phase      <= n_phase;
                r_steps_left <= n_steps_left;
                r_wait       <= n_wait;
                r_coils      <= n_coils;
                r_moving     <= n_moving;
                r_dir        <= n_dir;
            end
        end
    end

    assign o_result.coils    = n_coils;
    assign o_result.stepped  = stepped;
    assign o_result.busy_res = n_moving;
    assign o_result.rejected = rejected;

`ifndef SYNTH
    a_step_keeps_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && stepped |=> r_moving)
        else $error("step applied but sequencer not busy");

    a_reject_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && rejected |=> $stable(r_phase) && $stable(r_steps_left) && $stable(r_coils))
        else $error("rejected move changed the state");

    a_idle_only_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_moving) |-> r_steps_left == '0)
        else $error("went idle with steps left");

    a_reject_not_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && rejected |-> !stepped && r_moving)
        else $error("reject while idle or together with a step");
`endif

endmodule

// File: hdl/shs_out_reg.sv
module shs_out_reg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  shs_pkg::t_result                  i_result,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [shs_pkg::M_TDATA_W-1:0]     o_data
);
    import shs_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = {1'b0, r_result.rejected, r_result.busy_res, r_result.stepped,
                      r_result.coils};

endmodule

// File: hdl/stepper_half_step_sequencer.sv
// Channel   Direction  Handshake                   Payload
// s_axis    in         tvalid / tready             tdata: step_count, direction; tuser: opcode
// m_axis    out        tvalid / tready             tdata: coils, stepped, busy_res, rejected
// cfg       in         wr_en (no back-pressure)    wr_data: step_interval
//
// Each request gives exactly one result, presented on m_axis after the input register and the result register.
// Requests are taken one per clock while m_axis does not stall; the path is the input
// register, the next-state logic and the result register.
// A stalled result holds both registers, and s_axis tready falls only when both are full.
// Synchronous active-low reset clears the valid flags and the sequencer state; the step interval resets to 1.
module stepper_half_step_sequencer #(
    parameter int COUNT_WIDTH = shs_pkg::DEF_COUNT_WIDTH,
    parameter int TIMER_WIDTH = shs_pkg::DEF_TIMER_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [shs_pkg::INTERVAL_W-1:0]    i_cfg_wr_data,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [15:0] step_count, [16] direction, [23:17] zero
    input  logic [shs_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    // [0] opcode
    input  logic                              i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [3:0] coils, [4] stepped, [5] busy_res, [6] rejected, [7] zero
    output logic [shs_pkg::M_TDATA_W-1:0]     o_m_axis_tdata
);
    import shs_pkg::*;

    logic    item_valid;
    t_item   item;
    logic    out_ready;
    t_result result;

    shs_in_reg u_in_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_opcode (i_s_axis_tuser),
        .i_data   (i_s_axis_tdata),
        .i_take   (out_ready),
        .o_valid  (item_valid),
        .o_item   (item)
    );

    shs_core #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_fire        (item_valid && out_ready),
        .i_item        (item),
        .o_result      (result)
    );

    shs_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (item_valid),
        .o_ready  (out_ready),
        .i_result (result),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_data   (o_m_axis_tdata)
    );

endmodule

// File: verif/stepper_half_step_sequencer_tb.sv
module stepper_half_step_sequencer_tb;
    import shs_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int MAX_GAP        = 18;
    localparam int SHOWN_ERRORS   = 10;

    typedef struct {
        logic                  op;
        logic [COUNT_IN_W-1:0] count;
        logic                  dir;
        bit                    known;
        t_result               res;
    } t_motor_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [INTERVAL_W-1:0] i_cfg_wr_data;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    // [15:0] step_count, [16] direction, [23:17] zero
    logic [S_TDATA_W-1:0]  i_s_axis_tdata;
    // [0] opcode
    logic                  i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    // [3:0] coils, [4] stepped, [5] busy_res, [6] rejected, [7] zero
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;

    // Motor state as the block should hold it.
    logic [INTERVAL_W-1:0] mot_interval = INTERVAL_RESET;
    logic [PHASE_W-1:0]    mot_phase    = '0;
    logic [COUNT_IN_W-1:0] mot_steps    = '0;
    logic [INTERVAL_W-1:0] mot_timer    = '0;
    logic [COIL_W-1:0]     mot_coils    = '0;
    logic                  mot_moving   = 1'b0;
    logic                  mot_dir      = DIR_BACKWARD;

    t_result pending_results[$];
    int      err_count  = 0;
    bit      calm       = 1'b0;
    bit      hold_req   = 1'b0;
    int      quiet_cycles = 0;

    // Rows with a typed result are the ones that can be read off at a glance.
    t_motor_row directed_rows[22] = '{
        '{OP_TICK, 16'h0000, DIR_BACKWARD, 1'b1, {4'h0, 1'b0, 1'b0, 1'b0}},
        '{OP_MOVE, 16'h0000, DIR_FORWARD,  1'b1, {4'h0, 1'b0, 1'b0, 1'b0}},
        '{OP_TICK, 16'hFFFF, DIR_FORWARD,  1'b1, {4'h0, 1'b0, 1'b0, 1'b0}},
        '{OP_MOVE, 16'h0001, DIR_FORWARD,  1'b1, {4'h9, 1'b1, 1'b1, 1'b0}},
        '{OP_MOVE, 16'hFFFF, DIR_FORWARD,  1'b1, {4'h9, 1'b0, 1'b1, 1'b1}},
        '{OP_TICK, 16'h0000, DIR_BACKWARD, 1'b1, {4'h9, 1'b0, 1'b0, 1'b0}},
        '{OP_MOVE, 16'h0003, DIR_BACKWARD, 1'b0, '0},
        '{OP_MOVE, 16'hFFFF, DIR_BACKWARD, 1'b0, '0},
        '{OP_TICK, 16'h0000, DIR_BACKWARD, 1'b0, '0},
        '{OP_TICK, 16'h0000, DIR_BACKWARD, 1'b0, '0},
        '{OP_TICK, 16'h0000, DIR_BACKWARD, 1'b0, '0},
        '{OP_MOVE, 16'h0009, DIR_FORWARD,  1'b0, '0},
        '{OP_TICK, 16'h0000, DIR_BACKWARD, 1'b0, '0},
        '{OP_TICK, 16'hFFFF, DIR_FORWARD,  1'b0, '0},
        '{OP_TICK, 16'h0000, DIR_BACKWARD, 1'b0, '0},
        '{OP_TICK, 16'h0000, DIR_BACKWARD, 1'b0, '0},
        '{OP_TICK, 16'h0000, DIR_BACKWARD, 1'b0, '0},
        '{OP_TICK, 16'h0000, DIR_BACKWARD, 1'b0, '0},
        '{OP_TICK, 16'h0000, DIR_BACKWARD, 1'b0, '0},
        '{OP_TICK, 16'h0000, DIR_BACKWARD, 1'b0, '0},
        '{OP_TICK, 16'h0000, DIR_BACKWARD, 1'b0, '0},
        '{OP_TICK, 16'h0000, DIR_BACKWARD, 1'b0, '0}
    };

    stepper_half_step_sequencer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic take_half_step();
        mot_coils = HALF_STEP_ROWS[mot_phase];
        if (mot_dir == DIR_FORWARD) begin
            mot_phase = mot_phase + 1'b1;
        end else begin
            mot_phase = mot_phase - 1'b1;
        end
        mot_timer = mot_interval;
    endtask

    task automatic predict_motor(input logic op, input logic [COUNT_IN_W-1:0] count,
                                 input logic dir, output t_result r);
        r = '0;
        if (op == OP_MOVE) begin
            if (mot_moving) begin
                r.rejected = 1'b1;
            end else if (count != 0) begin
                mot_dir = dir;
                take_half_step();
                mot_steps  = count - 1'b1;
                mot_moving = 1'b1;
                r.stepped  = 1'b1;
            end
        end else if (mot_moving) begin
            if (mot_timer != 0) begin
                mot_timer = mot_timer - 1'b1;
            end
            // A zero interval runs out on the first tick, like an interval of one.
            if (mot_timer == 0) begin
                if (mot_steps != 0) begin
                    take_half_step();
                    mot_steps = mot_steps - 1'b1;
                    r.stepped = 1'b1;
                end else begin
                    mot_moving = 1'b0;
                end
            end
        end
        r.coils    = mot_coils;
        r.busy_res = mot_moving;
    endtask

    task automatic offer_request(input logic op, input logic [COUNT_IN_W-1:0] count,
                                 input logic dir, input bit known, input t_result typed);
        int      gap;
        t_result r;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap) begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {7'b0, dir, count};
        i_s_axis_tuser  = op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_motor(op, count, dir, r);
        pending_results.push_back(known ? typed : r);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        wait (pending_results.size() == 0);
    endtask

    task automatic load_interval(input logic [INTERVAL_W-1:0] value);
        drain_results();
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = value;
        mot_interval  = value;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
    endtask

    // Result side: random stalls, plus one long hold-off when the sender asks for it.
    initial begin
        int      stall;
        t_result want;
        t_result got;
        i_m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                stall = calm ? 0 : $urandom_range(0, MAX_GAP);
            end
            repeat (stall) begin
                @(negedge i_clk);
                i_m_axis_tready = 1'b0;
            end
            @(negedge i_clk);
            i_m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            got.coils    = o_m_axis_tdata[3:0];
            got.stepped  = o_m_axis_tdata[4];
            got.busy_res = o_m_axis_tdata[5];
            got.rejected = o_m_axis_tdata[6];
            if (pending_results.size() == 0) begin
                err_count++;
                if (err_count <= SHOWN_ERRORS) begin
                    $display("unexpected result: coils=%h stepped=%b busy=%b rejected=%b",
                             got.coils, got.stepped, got.busy_res, got.rejected);
                end
            end else begin
                want = pending_results.pop_front();
                if (got.coils !== want.coils || got.stepped !== want.stepped ||
                    got.busy_res !== want.busy_res || got.rejected !== want.rejected) begin
                    err_count++;
                    if (err_count <= SHOWN_ERRORS) begin
                        $display("mismatch: expected coils=%h stepped=%b busy=%b rejected=%b",
                                 want.coils, want.stepped, want.busy_res, want.rejected);
                        $display("          actual   coils=%h stepped=%b busy=%b rejected=%b",
                                 got.coils, got.stepped, got.busy_res, got.rejected);
                    end
                end
            end
        end
    end

    // Ends the run when neither side moves a request for too long.
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        logic [INTERVAL_W-1:0] intervals[7] = '{16'd0, 16'd2, 16'd5, 16'd1, 16'd3, 16'd9,
                                                16'hFFFF};
        logic                  op;
        logic [COUNT_IN_W-1:0] count;
        logic                  dir;
        int                    pick;
        int                    n_items;

        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = OP_TICK;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // The reset interval of one is in force for the directed rows.
        foreach (directed_rows[k]) begin
            offer_request(directed_rows[k].op, directed_rows[k].count, directed_rows[k].dir,
                          directed_rows[k].known, directed_rows[k].res);
        end

        foreach (intervals[p]) begin
            load_interval(intervals[p]);
            // The last phase leaves the motor busy on the longest interval.
            n_items = (p == 6) ? 30 : 300;
            for (int j = 0; j < n_items; j++) begin
                if (p == 1 && j == 150) begin
                    hold_req = 1'b1;
                end
                if (p == 2 && j == 200) begin
                    drain_results();
                end
                if ($urandom_range(0, 59) == 0) begin
                    calm = !calm;
                end
                count = COUNT_IN_W'($urandom);
                dir   = 1'($urandom);
                if (mot_moving) begin
                    op = ($urandom_range(0, 99) < 8) ? OP_MOVE : OP_TICK;
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 10) begin
                        op = OP_TICK;
                    end else begin
                        op = OP_MOVE;
                        if (pick < 15) begin
                            count = '0;
                        end else begin
                            count = COUNT_IN_W'($urandom_range(1, 6));
                        end
                    end
                end
                offer_request(op, count, dir, 1'b0, '0);
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
